// ----- sv/box_collision_side_merge_assert.svh -----
// ----------------------------------------------------------------------------
// Box collision side merge assertion macros
// Clocked assertion helpers shared by bcsm_merge and the top module. They use the
// clk and rst_n signals of the module in which they stand.
// ----------------------------------------------------------------------------
`ifndef BOX_COLLISION_SIDE_MERGE_ASSERT_SVH
`define BOX_COLLISION_SIDE_MERGE_ASSERT_SVH

`ifndef SYNTHESIS
`define BCSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BCSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BCSM_ASSERT(lbl, prop, msg)
`define BCSM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/bcsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box collision side merge package
// Widths, side codes and the types shared by the modules of the block.
// ----------------------------------------------------------------------------
package bcsm_pkg;

  localparam int COORD_BITS = 15;
  localparam int LEN_BITS   = COORD_BITS - 1;
  localparam int EXT_BITS   = COORD_BITS + 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [LEN_BITS-1:0]   len_t;
  typedef logic signed [EXT_BITS-1:0]   ext_t;
  typedef logic        [1:0]            side_t;

  localparam side_t SIDE_NONE = 2'd0;
  localparam side_t SIDE_NEAR = 2'd1;
  localparam side_t SIDE_FAR  = 2'd2;

  typedef struct packed {
    logic   start_req;
    coord_t a_x;
    coord_t a_y;
    len_t   a_w;
    len_t   a_h;
    coord_t b_x;
    coord_t b_y;
    len_t   b_w;
    len_t   b_h;
  } box_pair_t;

  typedef struct packed {
    logic   hit;
    side_t  h_side;
    side_t  v_side;
    len_t   depth_x;
    len_t   depth_y;
    coord_t ix;
    coord_t iy;
    len_t   iw;
    len_t   ih;
  } pair_res_t;

endpackage

// ----- sv/bcsm_intersect.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box pair intersection
// Intersects the subject and target boxes and works out the struck side of
// the subject and the penetration depth for one pair.
// ----------------------------------------------------------------------------
module bcsm_intersect
  import bcsm_pkg::*;
(
  input  box_pair_t pair,
  output pair_res_t res
);

  function automatic side_t axis_side(ext_t bpos, ext_t bend, ext_t ipos, ext_t iend);
    logic near_hit;
    logic far_hit;
    near_hit = (bpos == ipos);
    far_hit  = (bend == iend);
    if (!near_hit && !far_hit) begin
      near_hit = ((bend - ipos) > (iend - bpos));
      far_hit  = !near_hit;
    end
    if (near_hit == far_hit) begin
      return SIDE_NONE;
    end
    return near_hit ? SIDE_NEAR : SIDE_FAR;
  endfunction

  ext_t  ax, ay, bx, by;
  ext_t  a_xend, a_yend, b_xend, b_yend;
  ext_t  ix, iy, ix_end, iy_end, iw, ih;
  logic  nonempty;
  side_t hs, vs;

  always_comb begin
    ax     = ext_t'(pair.a_x);
    ay     = ext_t'(pair.a_y);
    bx     = ext_t'(pair.b_x);
    by     = ext_t'(pair.b_y);
    a_xend = ax + ext_t'(pair.a_w);
    a_yend = ay + ext_t'(pair.a_h);
    b_xend = bx + ext_t'(pair.b_w);
    b_yend = by + ext_t'(pair.b_h);
    ix     = (ax > bx) ? ax : bx;
    iy     = (ay > by) ? ay : by;
    ix_end = (a_xend < b_xend) ? a_xend : b_xend;
    iy_end = (a_yend < b_yend) ? a_yend : b_yend;
    iw     = ix_end - ix;
    ih     = iy_end - iy;
    nonempty = (|pair.a_w) && (|pair.a_h) && (|pair.b_w) && (|pair.b_h);
    hs     = axis_side(ax, a_xend, ix, ix_end);
    vs     = axis_side(ay, a_yend, iy, iy_end);

    res.hit     = nonempty && (iw > ext_t'(0)) && (ih > ext_t'(0));
    res.h_side  = SIDE_NONE;
    res.v_side  = SIDE_NONE;
    res.depth_x = '0;
    res.depth_y = '0;
    res.ix      = coord_t'(ix);
    res.iy      = coord_t'(iy);
    res.iw      = len_t'(iw);
    res.ih      = len_t'(ih);
    if ((iw < ih) && (hs != SIDE_NONE)) begin
      res.h_side  = hs;
      res.depth_x = len_t'(iw);
    end else if (vs != SIDE_NONE) begin
      res.v_side  = vs;
      res.depth_y = len_t'(ih);
    end
  end

endmodule

// ----- sv/bcsm_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running hit merge
// Holds the running hit and merges each pair result into it. The registers
// double as the result register of the block.
// ----------------------------------------------------------------------------
`include "box_collision_side_merge_assert.svh"

module bcsm_merge
  import bcsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  logic      start_req,
  input  pair_res_t pair,
  output logic      pair_hit,
  output side_t     h_side,
  output side_t     v_side,
  output len_t      depth_x,
  output len_t      depth_y,
  output coord_t    span_x,
  output coord_t    span_y,
  output len_t      span_w,
  output len_t      span_h,
  output logic      any_hit
);

  typedef struct packed {
    side_t side;
    len_t  depth;
  } axis_t;

  function automatic axis_t merge_axis(axis_t run, axis_t fresh);
    axis_t r;
    r = run;
    if (fresh.side != SIDE_NONE) begin
      if ((run.depth < fresh.depth) &&
          ((fresh.side == run.side) || (run.side == SIDE_NONE))) begin
        r = fresh;
      end else if (fresh.side != run.side) begin
        r.side  = SIDE_NONE;
        r.depth = '0;
      end
    end
    return r;
  endfunction

  logic   pair_hit_r, pair_hit_nxt;
  logic   any_hit_r, any_hit_nxt;
  axis_t  h_r, h_nxt, v_r, v_nxt;
  coord_t span_x_r, span_x_nxt, span_y_r, span_y_nxt;
  len_t   span_w_r, span_w_nxt, span_h_r, span_h_nxt;
  axis_t  h_base, v_base;
  coord_t sx_base, sy_base;
  len_t   sw_base, sh_base;
  logic   any_base;

  always_comb begin
    h_base   = h_r;
    v_base   = v_r;
    sx_base  = span_x_r;
    sy_base  = span_y_r;
    sw_base  = span_w_r;
    sh_base  = span_h_r;
    any_base = any_hit_r;
    if (start_req) begin
      h_base   = '0;
      v_base   = '0;
      sx_base  = '0;
      sy_base  = '0;
      sw_base  = '0;
      sh_base  = '0;
      any_base = 1'b0;
    end

    h_nxt        = h_base;
    v_nxt        = v_base;
    span_x_nxt   = sx_base;
    span_y_nxt   = sy_base;
    span_w_nxt   = sw_base;
    span_h_nxt   = sh_base;
    any_hit_nxt  = any_base;
    pair_hit_nxt = pair.hit;
    if (pair.hit) begin
      any_hit_nxt = 1'b1;
      if (!any_base) begin
        h_nxt      = '{side: pair.h_side, depth: pair.depth_x};
        v_nxt      = '{side: pair.v_side, depth: pair.depth_y};
        span_x_nxt = pair.ix;
        span_y_nxt = pair.iy;
        span_w_nxt = pair.iw;
        span_h_nxt = pair.ih;
      end else begin
        h_nxt      = merge_axis(h_base, '{side: pair.h_side, depth: pair.depth_x});
        v_nxt      = merge_axis(v_base, '{side: pair.v_side, depth: pair.depth_y});
        span_x_nxt = (pair.ix < sx_base) ? pair.ix : sx_base;
        span_y_nxt = (pair.iy < sy_base) ? pair.iy : sy_base;
        span_w_nxt = (pair.iw > sw_base) ? pair.iw : sw_base;
        span_h_nxt = (pair.ih > sh_base) ? pair.ih : sh_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_hit_r <= 1'b0;
      any_hit_r  <= 1'b0;
      h_r        <= '0;
      v_r        <= '0;
      span_x_r   <= '0;
      span_y_r   <= '0;
      span_w_r   <= '0;
      span_h_r   <= '0;
    end else if (load) begin
      pair_hit_r <= pair_hit_nxt;
      any_hit_r  <= any_hit_nxt;
      h_r        <= h_nxt;
      v_r        <= v_nxt;
      span_x_r   <= span_x_nxt;
      span_y_r   <= span_y_nxt;
      span_w_r   <= span_w_nxt;
      span_h_r   <= span_h_nxt;
    end
  end

  assign pair_hit = pair_hit_r;
  assign any_hit  = any_hit_r;
  assign h_side   = h_r.side;
  assign depth_x  = h_r.depth;
  assign v_side   = v_r.side;
  assign depth_y  = v_r.depth;
  assign span_x   = span_x_r;
  assign span_y   = span_y_r;
  assign span_w   = span_w_r;
  assign span_h   = span_h_r;

  // A side of none always carries a zero depth, and a pair hit implies a running hit.
  `BCSM_ASSERT(a_h_none_zero, (h_r.side != SIDE_NONE) || (h_r.depth == '0), "h depth alone")
  `BCSM_ASSERT(a_v_none_zero, (v_r.side != SIDE_NONE) || (v_r.depth == '0), "v depth alone")
  `BCSM_ASSERT(a_pair_any, !pair_hit_r || any_hit_r, "pair hit without running hit")
  `BCSM_ASSERT(a_hold, !load |=> $stable({h_r, v_r, any_hit_r}), "state moved without load")
  `BCSM_ASSERT(a_fall_start, $fell(any_hit_r) |-> $past(load && start_req), "lost without start")

endmodule

// ----- sv/box_collision_side_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box collision side merge
// An item taken into the input register is merged into the result register
// when the output is free, and its result is offered from then on.
// Throughput: one item per cycle while the output does not stall. While a
// result waits, one more item can enter the input register, after which the
// input is stalled. Reset (synchronous, active low) empties both stages and
// clears the running hit, as if a start had been seen.
// ----------------------------------------------------------------------------
`include "box_collision_side_merge_assert.svh"

module box_collision_side_merge
  import bcsm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  logic   in_start_req,
  input  coord_t in_a_x,
  input  coord_t in_a_y,
  input  len_t   in_a_w,
  input  len_t   in_a_h,
  input  coord_t in_b_x,
  input  coord_t in_b_y,
  input  len_t   in_b_w,
  input  len_t   in_b_h,
  output logic   out_valid,
  input  logic   out_stall,
  output logic   out_pair_hit,
  output side_t  out_h_side,
  output side_t  out_v_side,
  output len_t   out_depth_x,
  output len_t   out_depth_y,
  output coord_t out_span_x,
  output coord_t out_span_y,
  output len_t   out_span_w,
  output len_t   out_span_h,
  output logic   out_any_hit
);

  logic      s1_valid_r, s1_valid_nxt;
  box_pair_t s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  logic      load;
  logic      in_accept;
  pair_res_t pair_res;

  assign load      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !load;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= '{start_req: in_start_req, a_x: in_a_x, a_y: in_a_y,
                     a_w: in_a_w, a_h: in_a_h, b_x: in_b_x, b_y: in_b_y,
                     b_w: in_b_w, b_h: in_b_h};
    end
  end

  bcsm_intersect u_intersect (
    .pair (s1_item_r),
    .res  (pair_res)
  );

  bcsm_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .start_req (s1_item_r.start_req),
    .pair      (pair_res),
    .pair_hit  (out_pair_hit),
    .h_side    (out_h_side),
    .v_side    (out_v_side),
    .depth_x   (out_depth_x),
    .depth_y   (out_depth_y),
    .span_x    (out_span_x),
    .span_y    (out_span_y),
    .span_w    (out_span_w),
    .span_h    (out_span_h),
    .any_hit   (out_any_hit)
  );

  assign out_valid = out_valid_r;

  `BCSM_ASSERT(a_stall_full, !in_stall || s1_valid_r, "input stalled with empty stage")
  `BCSM_ASSERT(a_load_out, load |=> out_valid_r, "loaded item not presented")
  `BCSM_ASSERT(a_no_drop, (out_valid_r && out_stall) |-> !load, "result overwritten while stalled")

endmodule

// ----- verif/box_collision_side_merge_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box collision side merge testbench
// Sends pairs of boxes through the block and predicts each running hit
// (struck sides, depths, overlap span and the hit flags) with a model of its
// own. Every result is checked field by field against the oldest prediction.
// A short directed list covers the side rules, cancelling, empty boxes and the
// coordinate extremes. Random pairs follow, mostly overlapping ones. Both
// sides idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module box_collision_side_merge_test;
  import bcsm_pkg::*;

  localparam int POS_MIN     = -(1 << (COORD_BITS - 1));
  localparam int POS_MAX     = (1 << (COORD_BITS - 1)) - 1;
  localparam int LEN_MAX     = (1 << LEN_BITS) - 1;
  localparam int RANDOM_PAIRS = 1230;
  localparam int QUIET_LIMIT = 2000;
  localparam int SQUEEZE_AT  = 400;
  localparam int SQUEEZE_LEN = 120;

  typedef struct packed {
    logic   pair_hit;
    side_t  h_side;
    side_t  v_side;
    len_t   depth_x;
    len_t   depth_y;
    coord_t span_x;
    coord_t span_y;
    len_t   span_w;
    len_t   span_h;
    logic   any_hit;
  } hit_summary_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   in_start_req = 1'b0;
  coord_t in_a_x = '0;
  coord_t in_a_y = '0;
  len_t   in_a_w = '0;
  len_t   in_a_h = '0;
  coord_t in_b_x = '0;
  coord_t in_b_y = '0;
  len_t   in_b_w = '0;
  len_t   in_b_h = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   out_pair_hit;
  side_t  out_h_side;
  side_t  out_v_side;
  len_t   out_depth_x;
  len_t   out_depth_y;
  coord_t out_span_x;
  coord_t out_span_y;
  len_t   out_span_w;
  len_t   out_span_h;
  logic   out_any_hit;

  box_collision_side_merge dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_start_req (in_start_req),
    .in_a_x       (in_a_x),
    .in_a_y       (in_a_y),
    .in_a_w       (in_a_w),
    .in_a_h       (in_a_h),
    .in_b_x       (in_b_x),
    .in_b_y       (in_b_y),
    .in_b_w       (in_b_w),
    .in_b_h       (in_b_h),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pair_hit (out_pair_hit),
    .out_h_side   (out_h_side),
    .out_v_side   (out_v_side),
    .out_depth_x  (out_depth_x),
    .out_depth_y  (out_depth_y),
    .out_span_x   (out_span_x),
    .out_span_y   (out_span_y),
    .out_span_w   (out_span_w),
    .out_span_h   (out_span_h),
    .out_any_hit  (out_any_hit)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  box_pair_t    pending_pairs[$];
  hit_summary_t expected_hits[$];
  box_pair_t    on_ports;
  hit_summary_t oldest;

  logic  run_first = 1'b1;
  side_t run_h = SIDE_NONE;
  side_t run_v = SIDE_NONE;
  int    run_dx = 0;
  int    run_dy = 0;
  int    run_sx = 0;
  int    run_sy = 0;
  int    run_sw = 0;
  int    run_sh = 0;

  int mismatches = 0;
  int pairs_total = 0;
  int pairs_taken = 0;
  int results_seen = 0;
  int overlaps = 0;
  int starts = 0;
  int input_stalls = 0;
  int send_idle = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int stall_pick;
  logic squeeze_done = 1'b0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d field %s is %0d, predicted %0d",
                                results_seen, name, got, want));
  endtask

  function automatic side_t struck_side(int pos, int len, int ipos, int ilen);
    logic near_hit, far_hit;
    near_hit = (pos == ipos);
    far_hit  = (pos + len == ipos + ilen);
    if (!near_hit && !far_hit) begin
      near_hit = (pos + len - ipos > ipos + ilen - pos);
      far_hit  = !near_hit;
    end
    if (near_hit == far_hit) return SIDE_NONE;
    return near_hit ? SIDE_NEAR : SIDE_FAR;
  endfunction

  task automatic fold_axis(inout side_t s, inout int d, input side_t ns, input int nd);
    if (ns != SIDE_NONE) begin
      if (d < nd && (ns == s || s == SIDE_NONE)) begin
        s = ns;
        d = nd;
      end else if (ns != s) begin
        s = SIDE_NONE;
        d = 0;
      end
    end
  endtask

  task automatic merge_pair(input box_pair_t p);
    int ax, ay, aw, ah, bx, by, bw, bh, ix, iy, iw, ih, dx, dy;
    side_t hs, vs, nh, nv;
    hit_summary_t r;
    ax = int'(p.a_x); ay = int'(p.a_y); aw = int'(p.a_w); ah = int'(p.a_h);
    bx = int'(p.b_x); by = int'(p.b_y); bw = int'(p.b_w); bh = int'(p.b_h);
    r.pair_hit = 1'b0;
    if (p.start_req) begin
      starts++;
      run_first = 1'b1;
      run_h = SIDE_NONE; run_v = SIDE_NONE;
      run_dx = 0; run_dy = 0;
      run_sx = 0; run_sy = 0; run_sw = 0; run_sh = 0;
    end
    if (aw > 0 && ah > 0 && bw > 0 && bh > 0) begin
      ix = (ax > bx) ? ax : bx;
      iy = (ay > by) ? ay : by;
      iw = ((ax + aw < bx + bw) ? ax + aw : bx + bw) - ix;
      ih = ((ay + ah < by + bh) ? ay + ah : by + bh) - iy;
      if (iw > 0 && ih > 0) begin
        r.pair_hit = 1'b1;
        overlaps++;
        hs = struck_side(ax, aw, ix, iw);
        vs = struck_side(ay, ah, iy, ih);
        nh = SIDE_NONE; nv = SIDE_NONE; dx = 0; dy = 0;
        if (iw < ih && hs != SIDE_NONE) begin
          nh = hs;
          dx = iw;
        end else if (vs != SIDE_NONE) begin
          nv = vs;
          dy = ih;
        end
        if (run_first) begin
          run_h = nh; run_v = nv; run_dx = dx; run_dy = dy;
          run_sx = ix; run_sy = iy; run_sw = iw; run_sh = ih;
          run_first = 1'b0;
        end else begin
          fold_axis(run_h, run_dx, nh, dx);
          fold_axis(run_v, run_dy, nv, dy);
          if (ix < run_sx) run_sx = ix;
          if (iy < run_sy) run_sy = iy;
          if (iw > run_sw) run_sw = iw;
          if (ih > run_sh) run_sh = ih;
        end
      end
    end
    r.h_side  = run_h;
    r.v_side  = run_v;
    r.depth_x = len_t'(run_dx);
    r.depth_y = len_t'(run_dy);
    r.span_x  = coord_t'(run_sx);
    r.span_y  = coord_t'(run_sy);
    r.span_w  = len_t'(run_sw);
    r.span_h  = len_t'(run_sh);
    r.any_hit = !run_first;
    expected_hits.insert(expected_hits.size(), r);
  endtask

  task automatic add_pair(input logic st, input int ax, input int ay, input int aw,
                          input int ah, input int bx, input int by, input int bw,
                          input int bh);
    box_pair_t p;
    p.start_req = st;
    p.a_x = coord_t'(ax); p.a_y = coord_t'(ay); p.a_w = len_t'(aw); p.a_h = len_t'(ah);
    p.b_x = coord_t'(bx); p.b_y = coord_t'(by); p.b_w = len_t'(bw); p.b_h = len_t'(bh);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  function automatic int clamp_pos(int v);
    if (v < POS_MIN) return POS_MIN;
    if (v > POS_MAX) return POS_MAX;
    return v;
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 48);
    return $urandom_range(1, LEN_MAX);
  endfunction

  function automatic int pick_idle(int n);
    int r;
    if ((n / 150) % 3 == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(9, 30);
  endfunction

  task automatic add_random_pair();
    int mode, ax, ay, aw, ah, bx, by, bw, bh, off;
    logic st;
    mode = $urandom_range(0, 99);
    st = ($urandom_range(0, 5) == 0);
    if (mode < 12) begin
      add_pair(1'($urandom_range(0, 1)), int'(coord_t'($urandom())),
               int'(coord_t'($urandom())),
               $urandom_range(0, LEN_MAX), $urandom_range(0, LEN_MAX),
               int'(coord_t'($urandom())), int'(coord_t'($urandom())),
               $urandom_range(0, LEN_MAX), $urandom_range(0, LEN_MAX));
    end else begin
      ax = $urandom_range(0, 2 * POS_MAX + 1);
      ax = ax + POS_MIN;
      ay = $urandom_range(0, 2 * POS_MAX + 1);
      ay = ay + POS_MIN;
      aw = pick_len(); ah = pick_len(); bw = pick_len(); bh = pick_len();
      off = $urandom_range(0, aw + bw + 16);
      bx = clamp_pos(ax - bw - 8 + off);
      off = $urandom_range(0, ah + bh + 16);
      by = clamp_pos(ay - bh - 8 + off);
      if (mode < 20) bx = ax;
      else if (mode < 28) bx = clamp_pos(ax + aw - bw);
      else if (mode < 34) by = ay;
      else if (mode < 40) by = clamp_pos(ay + ah - bh);
      else if (mode < 44) begin
        case ($urandom_range(0, 3))
          0: aw = 0;
          1: ah = 0;
          2: bw = 0;
          default: bh = 0;
        endcase
      end
      add_pair(st, ax, ay, aw, ah, bx, by, bw, bh);
    end
  endtask

  // Driver: presents queued pairs, holding each one while the block stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) input_stalls++;
      if (in_valid && !in_stall) begin
        merge_pair(on_ports);
        pairs_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (send_idle > 0) begin
          send_idle--;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          on_ports = pending_pairs.pop_front();
          in_start_req <= on_ports.start_req;
          in_a_x <= on_ports.a_x;
          in_a_y <= on_ports.a_y;
          in_a_w <= on_ports.a_w;
          in_a_h <= on_ports.a_h;
          in_b_x <= on_ports.b_x;
          in_b_y <= on_ports.b_y;
          in_b_w <= on_ports.b_w;
          in_b_h <= on_ports.b_h;
          in_valid <= 1'b1;
          send_idle = pick_idle(pairs_taken);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result and decides the receiver's stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no pair pending", results_seen));
        end else begin
          oldest = expected_hits.pop_front();
          check_field("pair_hit", int'(out_pair_hit), int'(oldest.pair_hit));
          check_field("h_side", int'(out_h_side), int'(oldest.h_side));
          check_field("v_side", int'(out_v_side), int'(oldest.v_side));
          check_field("depth_x", int'(out_depth_x), int'(oldest.depth_x));
          check_field("depth_y", int'(out_depth_y), int'(oldest.depth_y));
          check_field("span_x", int'(out_span_x), int'(oldest.span_x));
          check_field("span_y", int'(out_span_y), int'(oldest.span_y));
          check_field("span_w", int'(out_span_w), int'(oldest.span_w));
          check_field("span_h", int'(out_span_h), int'(oldest.span_h));
          check_field("any_hit", int'(out_any_hit), int'(oldest.any_hit));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
        squeeze_done = 1'b1;
        hold_left = SQUEEZE_LEN - 1;
        out_stall <= 1'b1;
      end else begin
        stall_pick = pick_idle(results_seen + 75);
        if (stall_pick > 0) begin
          hold_left = stall_pick - 1;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no progress for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    // Side rules, deeper and shallower hits, cancelling and starts.
    add_pair(1, 0, 0, 10, 10, 100, 100, 10, 10);
    add_pair(0, 5, 0, 10, 100, 0, 0, 8, 100);
    add_pair(0, 5, 0, 10, 100, 0, 0, 12, 100);
    add_pair(0, 5, 0, 10, 100, 0, 0, 6, 100);
    add_pair(0, 0, 0, 10, 100, 7, 0, 20, 100);
    add_pair(1, 0, 5, 100, 10, 0, 0, 100, 8);
    add_pair(0, 0, 0, 100, 10, 0, 7, 100, 20);
    add_pair(0, 0, 0, 100, 10, 0, 4, 100, 20);
    add_pair(1, 0, 0, 100, 100, 40, 40, 10, 10);
    add_pair(0, 0, 0, 100, 100, 10, 10, 10, 20);
    add_pair(0, 0, 0, 100, 100, 80, 10, 10, 20);
    add_pair(0, 0, 0, 10, 10, 0, 0, 10, 10);
    add_pair(0, 0, 0, 10, 10, 10, 0, 10, 10);
    add_pair(0, 0, 0, 0, 10, 0, 0, 10, 10);
    add_pair(0, 0, 0, 10, 0, 0, 0, 10, 10);
    add_pair(0, 0, 0, 10, 10, 0, 0, 0, 10);
    add_pair(0, 0, 0, 10, 10, 0, 0, 10, 0);
    add_pair(1, POS_MIN, POS_MIN, LEN_MAX, LEN_MAX, POS_MIN, POS_MIN, LEN_MAX, LEN_MAX);
    add_pair(0, POS_MAX, POS_MAX, LEN_MAX, LEN_MAX, POS_MAX, POS_MAX, LEN_MAX, LEN_MAX);
    add_pair(0, POS_MIN, 0, LEN_MAX, LEN_MAX, 0, POS_MIN, LEN_MAX, LEN_MAX);
    add_pair(0, POS_MIN, POS_MAX, LEN_MAX, 1, -1, POS_MAX, 1, LEN_MAX);
    add_pair(1, 3, 3, 1, 1, 3, 3, 1, 1);
    add_pair(1, 0, 0, 10, 10, 50, 50, 5, 5);
    repeat (RANDOM_PAIRS) add_random_pair();
    pairs_total = pending_pairs.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (pairs_taken < pairs_total || expected_hits.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_hits.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", expected_hits.size()));
    $display("Merged %0d box pairs (%0d overlapping, %0d after a start), %0d results checked.",
             pairs_taken, overlaps, starts, results_seen);
    $display("Input held off on %0d cycles; %0d mismatches.", input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
